FILE: rtl/fqbe_pkg.sv
package fqbe_pkg;

  // Ring size
  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int LEN_W     = 24;
  localparam int TIME_W    = 48;
  localparam int WIN_W     = 31;
  localparam int BYTES_W   = LEN_W + 1;
  localparam int SPAN_W    = TIME_W + 1;
  localparam int OUT_CNT_W = 7;
  localparam int ENTRY_W   = LEN_W + TIME_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = WIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTE_BUDGET = 1'b0,
    CFG_AGE_WINDOW  = 1'b1
  } cfg_reg_t;

  localparam logic [LEN_W-1:0] BUDGET_RESET = LEN_W'(1048576);
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10000);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [TIME_W-1:0] frame_time_ms;
    logic [LEN_W-1:0]  frame_len;
  } in_item_t;

  typedef struct packed {
    logic              accept;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] ts;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] budget;
    logic [WIN_W-1:0] window;
  } cfg_t;

  typedef struct packed {
    logic [SPAN_W-1:0]    span_ms;
    logic [LEN_W-1:0]     byte_total;
    logic [OUT_CNT_W-1:0] frame_count;
    logic [OUT_CNT_W-1:0] evicted;
    logic                 accepted;
  } res_t;

  localparam int IN_W  = $bits(in_item_t);
  localparam int OUT_W = $bits(res_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL_DROP,
    ST_APPEND,
    ST_BYTES,
    ST_AGE,
    ST_LOAD,
    ST_DONE
  } back_state_t;

endpackage

FILE: rtl/fqbe_ram.sv
module fqbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fqbe_front.sv
module fqbe_front
  import fqbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [LEN_W-1:0] budget;
  logic [WIN_W-1:0] window;
  in_item_t         item;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RESET;
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BYTE_BUDGET: budget <= cfg_wdata[LEN_W-1:0];
        CFG_AGE_WINDOW:  window <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.budget = budget;
  assign cfg.window = window;

  // Classify: zero length or above budget is a reject
  assign item          = in_item_t'(s_tdata);
  assign s_tready      = !q_full;
  assign q_push        = s_tvalid && !q_full;
  assign q_cmd.accept  = (item.frame_len != '0) && (item.frame_len <= budget);
  assign q_cmd.len     = item.frame_len;
  assign q_cmd.ts      = item.frame_time_ms;

endmodule

FILE: rtl/fqbe_cmd_queue.sv
module fqbe_cmd_queue
  import fqbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QFILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (fill == QFILL_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= ptr_inc(wptr);
      end
      if (do_pop) begin
        rptr <= ptr_inc(rptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= QFILL_W'(QUEUE_DEPTH))
    else $error("command queue fill beyond depth");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill != '0))
    else $error("command queue lost a pushed command");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wptr == rptr))
    else $error("command queue pointers disagree when empty");

endmodule

FILE: rtl/fqbe_back.sv
module fqbe_back
  import fqbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             q_valid,
  output logic             q_pop,
  input  cmd_t             q_cmd,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  back_state_t        state;
  back_state_t        state_next;
  back_state_t        ret_state;
  back_state_t        ret_state_next;
  logic [IDX_W-1:0]   oldest_index;
  logic [IDX_W-1:0]   oldest_index_next;
  logic [CNT_W-1:0]   held_count;
  logic [CNT_W-1:0]   held_count_next;
  logic [BYTES_W-1:0] held_bytes;
  logic [BYTES_W-1:0] held_bytes_next;
  logic [CNT_W-1:0]   evicted;
  logic [CNT_W-1:0]   evicted_next;
  cmd_t               cur;
  cmd_t               cur_next;
  logic [LEN_W-1:0]   oldest_len;
  logic [LEN_W-1:0]   oldest_len_next;
  logic [TIME_W-1:0]  oldest_time;
  logic [TIME_W-1:0]  oldest_time_next;
  logic [TIME_W-1:0]  newest_time;
  logic [TIME_W-1:0]  newest_time_next;
  logic               out_valid;
  logic               out_valid_next;
  res_t               out_data;
  res_t               out_data_next;

  logic               out_free;
  logic               ring_full;
  logic               over_budget;
  logic               too_old;
  logic               drop;
  logic               res_load;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W:0]     slot_sum;
  logic [IDX_W-1:0]   slot;
  logic signed [SPAN_W-1:0] age_diff;
  logic [SPAN_W-1:0]  span;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;

  fqbe_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata({cur.ts, cur.len}),
    .raddr(idx_inc),
    .rdata(ram_rdata)
  );

  assign out_free  = !out_valid || m_tready;
  assign ring_full = (held_count == CNT_W'(DEPTH));
  assign idx_inc   = (oldest_index == IDX_W'(DEPTH - 1)) ? '0 : oldest_index + 1'b1;
  assign slot_sum  = {1'b0, oldest_index} + (IDX_W + 1)'(held_count);
  assign slot      = (slot_sum >= (IDX_W + 1)'(DEPTH)) ?
                     IDX_W'(slot_sum - (IDX_W + 1)'(DEPTH)) : IDX_W'(slot_sum);

  assign over_budget = (held_bytes > {1'b0, cfg.budget}) && (held_count > CNT_W'(1));
  assign age_diff    = $signed({1'b0, cur.ts}) - $signed({1'b0, oldest_time});
  assign too_old     = (held_count > CNT_W'(1)) &&
                       (age_diff > $signed({{(SPAN_W - WIN_W){1'b0}}, cfg.window}));
  assign span        = (held_count == '0) ? '0 :
                       ({1'b0, newest_time} - {1'b0, oldest_time});

  assign drop = (state == ST_FULL_DROP) || ((state == ST_BYTES) && over_budget) ||
                ((state == ST_AGE) && too_old);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_cmd.accept) begin
          state_next = ring_full ? ST_FULL_DROP : ST_APPEND;
        end
      end
      ST_FULL_DROP: state_next = ST_LOAD;
      ST_APPEND:    state_next = ST_BYTES;
      ST_BYTES:     state_next = over_budget ? ST_LOAD : ST_AGE;
      ST_AGE:       state_next = too_old ? ST_LOAD : ST_DONE;
      ST_LOAD:      state_next = ret_state;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    q_pop             = 1'b0;
    ram_we            = 1'b0;
    res_load          = 1'b0;
    ret_state_next    = ret_state;
    oldest_index_next = oldest_index;
    held_count_next   = held_count;
    held_bytes_next   = held_bytes;
    evicted_next      = evicted;
    cur_next          = cur;
    oldest_len_next   = oldest_len;
    oldest_time_next  = oldest_time;
    newest_time_next  = newest_time;

    unique case (state)
      ST_IDLE: begin
        if (q_valid && (q_cmd.accept || out_free)) begin
          q_pop        = 1'b1;
          res_load     = !q_cmd.accept;
          cur_next     = q_cmd;
          evicted_next = '0;
        end
      end
      ST_FULL_DROP: ret_state_next = ST_APPEND;
      ST_APPEND: begin
        ram_we           = 1'b1;
        held_count_next  = held_count + 1'b1;
        held_bytes_next  = held_bytes + {1'b0, cur.len};
        newest_time_next = cur.ts;
        if (held_count == '0) begin
          oldest_len_next  = cur.len;
          oldest_time_next = cur.ts;
        end
      end
      ST_BYTES: ret_state_next = ST_BYTES;
      ST_AGE:   ret_state_next = ST_AGE;
      ST_LOAD: begin
        {oldest_time_next, oldest_len_next} = ram_rdata;
      end
      ST_DONE:  res_load = out_free;
      default: ;
    endcase

    // Drop the oldest entry; its successor is read back in the load step
    if (drop) begin
      held_bytes_next   = held_bytes - {1'b0, oldest_len};
      oldest_index_next = idx_inc;
      held_count_next   = held_count - 1'b1;
      evicted_next      = evicted + 1'b1;
    end
  end

  always_comb begin
    out_data_next.accepted    = (state == ST_DONE);
    out_data_next.evicted     = (state == ST_DONE) ? OUT_CNT_W'(evicted) : '0;
    out_data_next.frame_count = OUT_CNT_W'(held_count);
    out_data_next.byte_total  = held_bytes[LEN_W-1:0];
    out_data_next.span_ms     = span;
    if (res_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ret_state    <= ST_IDLE;
      oldest_index <= '0;
      held_count   <= '0;
      held_bytes   <= '0;
      evicted      <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      ret_state    <= ret_state_next;
      oldest_index <= oldest_index_next;
      held_count   <= held_count_next;
      held_bytes   <= held_bytes_next;
      evicted      <= evicted_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    oldest_len  <= oldest_len_next;
    oldest_time <= oldest_time_next;
    newest_time <= newest_time_next;
    if (res_load) begin
      out_data <= out_data_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(DEPTH))
    else $error("held count beyond ring depth");

  a_bytes_fit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !held_bytes[BYTES_W-1])
    else $error("held bytes overflow at rest");

  a_load_after_drop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ($past(state) == ST_FULL_DROP || $past(state) == ST_BYTES ||
                            $past(state) == ST_AGE))
    else $error("oldest entry reload without a drop");

  a_reject_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.accepted) |-> (out_data.evicted == '0))
    else $error("rejected push reports evictions");

  a_accept_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.accepted) |-> (out_data.frame_count != '0))
    else $error("accepted push leaves an empty queue");

endmodule

FILE: rtl/frame_queue_budget_evictor_unit.sv
// Frame queue with a byte budget and an age window.
//
// Input stream (s_*): one transaction pushes one frame descriptor. The front
// end classifies it (zero length or above byte_budget is a reject) and parks
// it in a two-entry command queue, so s_tready stays high while the back end
// is busy with an earlier push.
// Output stream (m_*): exactly one result transaction per push, in order,
// giving accept flag, eviction count, entries held, bytes held and the span
// between newest and oldest timestamps.
// Timing: with the back end idle, a rejected push passes through the command
// queue and then the output register. An accepted push steps through append,
// byte check and age check, with a drop and a read back of the new oldest
// entry from the descriptor RAM per evicted entry; the RAM read is registered.
// Reset (rst, synchronous) empties the queue, restores the register defaults
// and drops any pending result; the RAM needs no clearing.
// A stalled receiver holds the result in the output register; the back end
// finishes its current push and then waits, and the input side keeps taking
// transactions until the command queue fills.
// Configuration: write cfg_wdata to register cfg_index when cfg_we is high,
// only while no push is in flight.
module frame_queue_budget_evictor_unit
  import fqbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // frame_len[23:0], frame_time_ms[71:24]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // accepted[0], evicted[7:1], frame_count[14:8],
                                           // byte_total[38:15], span_ms[87:39]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_pop_cmd;

  // Front end: registers and classification
  fqbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // Decouple front and back
  fqbe_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_cmd  (q_pop_cmd)
  );

  // Back end: ring, eviction sequencer and result register
  fqbe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_cmd   (q_pop_cmd),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule
